@@ design/krcs_pkg.sv @@
// package for the 4x4 keypad row-column reversal scanner
// types, port patterns and the scan code table; no dependencies
`default_nettype none

package krcs_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_nibble;
    typedef logic [15:0] t_count;
    typedef logic [4:0]  t_key_value;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_REVERSE,
        PH_RELEASE
    } t_scan_phase;

    typedef struct packed {
        logic       known;
        t_key_value value;
    } t_key_info;

    localparam int     KEY_COUNT      = 16;
    localparam t_count DEBOUNCE_RESET = 16'd10;
    localparam t_count COUNT_MAX      = 16'hffff;
    localparam t_byte  IDLE_DRIVE     = 8'h0f;
    localparam t_byte  NO_KEY_CODE    = 8'hff;
    localparam t_nibble ALL_HIGH      = 4'hf;

    localparam t_byte CODE_TAB [KEY_COUNT] = '{
        8'h7e, 8'h7d, 8'h7b, 8'h77, 8'hbe, 8'hbd, 8'hbb, 8'hb7,
        8'hde, 8'hdd, 8'hdb, 8'hd7, 8'hee, 8'hed, 8'heb, 8'he7
    };

    localparam t_key_value VALUE_TAB [KEY_COUNT] = '{
        5'd17, 5'd18, 5'd19, 5'd20, 5'd3, 5'd6, 5'd9, 5'd7,
        5'd2,  5'd5,  5'd8,  5'd0,  5'd1, 5'd4, 5'd7, 5'd15
    };

endpackage

`default_nettype wire

@@ design/krcs_in_if.sv @@
// sample channel: valid, ready and the sampled port pins
// depends on krcs_pkg
`default_nettype none

interface krcs_in_if;
    logic           valid;
    logic           ready;
    krcs_pkg::t_byte port_pins;

    modport source (output valid, output port_pins, input ready);
    modport sink   (input valid, input port_pins, output ready);
endinterface

`default_nettype wire

@@ design/krcs_out_if.sv @@
// result channel: valid, ready, drive pattern and key report
// depends on krcs_pkg
`default_nettype none

interface krcs_out_if;
    logic                 valid;
    logic                 ready;
    krcs_pkg::t_byte      port_drive;
    logic                 key_event;
    logic                 key_known;
    krcs_pkg::t_key_value key_value;
    krcs_pkg::t_byte      scan_code;

    modport source (output valid, output port_drive, output key_event, output key_known,
                    output key_value, output scan_code, input ready);
    modport sink   (input valid, input port_drive, input key_event, input key_known,
                    input key_value, input scan_code, output ready);
endinterface

`default_nettype wire

@@ design/krcs_decode.sv @@
// scan code to key value lookup over the 16-entry table
// depends on krcs_pkg
`default_nettype none

module krcs_decode (
    input  wire krcs_pkg::t_byte     i_code,
    output      krcs_pkg::t_key_info o_info
);
    import krcs_pkg::*;

    logic [KEY_COUNT-1:0] hit;
    t_key_value           value;

    // table codes are unique, so at most one entry hits
    always_comb begin
        value = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            hit[k] = (CODE_TAB[k] == i_code);
            if (hit[k]) begin
                value = value | VALUE_TAB[k];
            end
        end
        o_info.known = |hit;
        o_info.value = value;
    end

endmodule

`default_nettype wire

@@ design/keypad_row_column_reversal_scan_top.sv @@
// keypad row-column reversal scanner: phase machine, debounce counter and result register
// depends on krcs_pkg, krcs_in_if, krcs_out_if, krcs_decode
//
//   channel   dir  handshake          payload
//   i_in      in   valid / ready      port_pins
//   o_out     out  valid / ready      port_drive, key_event, key_known, key_value, scan_code
//   i_cfg     in   i_cfg_we           i_cfg_data (debounce_ticks)
//
// one sample per cycle while i_in.ready is high; its result is in the output register in the cycle after acceptance
// the phase machine, the debounce add and compare and the table lookup form the only path
// reset is synchronous: phase idle, count zero, latches all high, debounce_ticks 10
// a stalled result holds the output register; ready drops only while it is full and not taken
`default_nettype none

module keypad_row_column_reversal_scan_top (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    krcs_in_if.sink                i_in,
    krcs_out_if.source             o_out,
    input  wire                    i_cfg_we,
    input  wire krcs_pkg::t_count  i_cfg_data
);
    import krcs_pkg::*;

    t_scan_phase r_phase, n_phase;
    t_count      r_count, n_count;
    t_nibble     r_col, n_col;
    t_nibble     r_row, n_row;
    t_count      r_deb_ticks;

    logic        r_out_valid;
    t_byte       r_drive;
    logic        r_event;
    logic        r_known;
    t_key_value  r_value;
    t_byte       r_code;

    logic        accept;
    logic        emit;
    t_nibble     cols;
    t_nibble     rows;
    t_byte       code;
    t_byte       drive;
    t_key_info   info;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign cols       = i_in.port_pins[3:0];
    assign rows       = i_in.port_pins[7:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_deb_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_col   <= ALL_HIGH;
            r_row   <= ALL_HIGH;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_col   = r_col;
        n_row   = r_row;
        emit    = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (cols != ALL_HIGH) begin
                        n_phase = PH_DEBOUNCE;
                        n_count = '0;
                    end
                end
                PH_DEBOUNCE: begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 16'd1;
                    end
                    if (n_count >= r_deb_ticks) begin
                        if (cols != ALL_HIGH) begin
                            n_col   = cols;
                            n_phase = PH_REVERSE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_REVERSE: begin
                    n_row = rows;
                    if (rows == ALL_HIGH) begin
                        emit    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    if (rows == ALL_HIGH) begin
                        emit    = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign code  = {n_row, n_col};
    assign drive = (n_phase == PH_REVERSE || n_phase == PH_RELEASE) ?
                   {ALL_HIGH, n_col} : IDLE_DRIVE;

    krcs_decode u_decode (
        .i_code (code),
        .o_info (info)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive <= drive;
            r_event <= emit;
            r_known <= emit && info.known;
            r_value <= emit ? info.value : '0;
            r_code  <= emit ? code : NO_KEY_CODE;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.port_drive = r_drive;
    assign o_out.key_event  = r_event;
    assign o_out.key_known  = r_known;
    assign o_out.key_value  = r_value;
    assign o_out.scan_code  = r_code;

    // a release report always returns the port to the idle pattern
    a_event_idle_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.key_event) |-> (o_out.port_drive == IDLE_DRIVE))
        else $error("key event without idle drive");

    // a transaction without a key event carries the no-key fields
    a_no_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.key_event) |->
        (o_out.scan_code == NO_KEY_CODE && !o_out.key_known && o_out.key_value == '0))
        else $error("non-event transaction carries key data");

    // reporting phases drive the rows high
    a_reverse_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_phase == PH_REVERSE || r_phase == PH_RELEASE)
            && $past(accept)) |-> (o_out.port_drive[7:4] == ALL_HIGH))
        else $error("reversed drive lost its row nibble");

    // back pressure only while a result is held
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready))
        else $error("input stalled without a held result");

endmodule

`default_nettype wire
